// ----- rtl/csvs_pkg.sv -----
// Shared types and constants of the CSV field splitter.
package csvs_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned RES_CNT_W   = 2;

  localparam logic [CHAR_W-1:0] ESCAPE_CHAR = 8'h5C;
  localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'h20;
  localparam logic [CHAR_W-1:0] TAB_CHAR    = 8'h09;
  localparam logic [CHAR_W-1:0] CR_CHAR     = 8'h0D;

  localparam logic [CHAR_W-1:0] DELIM_0_RST = 8'd44;
  localparam logic [CHAR_W-1:0] QUOTE_0_RST = 8'd34;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELIM_0     = 3'd0,
    REG_DELIM_1     = 3'd1,
    REG_DELIM_2     = 3'd2,
    REG_DELIM_3     = 3'd3,
    REG_DELIM_COUNT = 3'd4,
    REG_QUOTE_0     = 3'd5,
    REG_QUOTE_1     = 3'd6,
    REG_QUOTE_COUNT = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [3:0][CHAR_W-1:0] delim;
    logic [2:0]             delim_count;
    logic [1:0][CHAR_W-1:0] quote;
    logic [1:0]             quote_count;
  } cfg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              char_present;
    logic              end_of_line;
  } item_t;

  typedef struct packed {
    kind_e             kind;
    logic [CHAR_W-1:0] char_value;
    logic [7:0]        field_index;
    logic [7:0]        field_count;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [RES_CNT_W-1:0]      cnt;
  } bundle_t;

  typedef struct packed {
    logic              escape_pending;
    logic              in_quote;
    logic [CHAR_W-1:0] open_quote_char;
    logic              field_nonempty;
    logic              skip_spaces;
    logic [7:0]        field_counter;
  } tok_state_t;

endpackage

// ----- rtl/csvs_if.sv -----
// Stream interfaces for characters in and tokens out.
interface csvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       char_present;
  logic       end_of_line;

  modport source (output valid, output char_in, output char_present, output end_of_line,
                  input ready);
  modport sink   (input valid, input char_in, input char_present, input end_of_line,
                  output ready);
endinterface

interface csvs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_value;
  logic [7:0] field_index;
  logic [7:0] field_count;
  logic       last;

  modport source (output valid, output kind, output char_value, output field_index,
                  output field_count, output last, input ready);
  modport sink   (input valid, input kind, input char_value, input field_index,
                  input field_count, input last, output ready);
endinterface

// ----- rtl/csv_field_splitter.sv -----
// Top level of the CSV field splitter: splits a character stream into field tokens.
//
//   channel   dir  payload                                             transfer
//   chr_i     in   char_in, char_present, end_of_line                  valid & ready
//   tok_o     out  kind, char_value, field_index, field_count, last    valid & ready
//   cfg_*     in   cfg_idx_i, cfg_wdata_i                              cfg_we_i
//
// One character is taken per cycle into the item register while ready is high; the
// decision logic between it and the result register updates the tokenizer state
// when the item loads the result register. An item yields 0 to 3 tokens, sent one
// per cycle from the result register while tok_o.ready is high.
// Reset clears all tokenizer state and loads the default delimiter and quote.
// A stalled output holds the result register; the item register still takes one
// more character, then ready drops until the last token of the bundle transfers.
module csv_field_splitter
  import csvs_pkg::*;
#(
  parameter int unsigned MAX_FIELDS = 255
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  csvs_in_if.sink               chr_i,
  csvs_out_if.source            tok_o
);

  cfg_t    cfg;
  item_t   item;
  bundle_t bundle;
  result_t out_res;
  logic    load, free, out_last;

  // Hold the configuration registers.
  csvs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign item.char_in      = chr_i.char_in;
  assign item.char_present = chr_i.char_present;
  assign item.end_of_line  = chr_i.end_of_line;

  // Classify each character and advance the tokenizer state.
  csvs_core #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (chr_i.valid),
    .in_ready_o (chr_i.ready),
    .item_i     (item),
    .free_i     (free),
    .load_o     (load),
    .bundle_o   (bundle)
  );

  // Serialize the tokens of one item onto the output channel.
  csvs_out_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .free_o      (free),
    .out_valid_o (tok_o.valid),
    .out_ready_i (tok_o.ready),
    .out_res_o   (out_res),
    .out_last_o  (out_last)
  );

  assign tok_o.kind        = out_res.kind;
  assign tok_o.char_value  = out_res.char_value;
  assign tok_o.field_index = out_res.field_index;
  assign tok_o.field_count = out_res.field_count;
  assign tok_o.last        = out_last;

`ifndef ASSERT_OFF
  // A new bundle must never overwrite tokens that have not all transferred.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!tok_o.valid || (tok_o.ready && out_last)))
    else $error("result register overwritten before its last token transferred");

  // A row end closes the item's tokens.
  a_row_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_o.valid && (tok_o.kind == KIND_ROW_END)) |-> tok_o.last)
    else $error("row end token not marked last");

  // Field indexes and counts stay within the saturation limit.
  a_index_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_o.valid |-> ((tok_o.field_index <= 8'(MAX_FIELDS)) &&
                     (tok_o.field_count <= 8'(MAX_FIELDS))))
    else $error("field index or count above limit");
`endif

endmodule

// ----- rtl/csvs_cfg_regs.sv -----
// Configuration registers of the CSV field splitter.
module csvs_cfg_regs
  import csvs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DELIM_0:     cfg_d.delim[0]    = cfg_wdata_i;
        REG_DELIM_1:     cfg_d.delim[1]    = cfg_wdata_i;
        REG_DELIM_2:     cfg_d.delim[2]    = cfg_wdata_i;
        REG_DELIM_3:     cfg_d.delim[3]    = cfg_wdata_i;
        REG_DELIM_COUNT: cfg_d.delim_count = cfg_wdata_i[2:0];
        REG_QUOTE_0:     cfg_d.quote[0]    = cfg_wdata_i;
        REG_QUOTE_1:     cfg_d.quote[1]    = cfg_wdata_i;
        REG_QUOTE_COUNT: cfg_d.quote_count = cfg_wdata_i[1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim       <= {8'd0, 8'd0, 8'd0, DELIM_0_RST};
      cfg_q.delim_count <= 3'd1;
      cfg_q.quote       <= {8'd0, QUOTE_0_RST};
      cfg_q.quote_count <= 2'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/csvs_core.sv -----
// Item register, tokenizer state and per-character decision logic.
module csvs_core
  import csvs_pkg::*;
#(
  parameter int unsigned MAX_FIELDS = 255
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  item_t   item_i,
  input  logic    free_i,
  output logic    load_o,
  output bundle_t bundle_o
);

  localparam logic [7:0] MaxCnt = 8'(MAX_FIELDS);

  logic       item_valid_q;
  item_t      item_q;
  tok_state_t st_q, st_d;
  logic       advance;

  logic       is_delim, is_quote, is_white;
  logic [2:0] dcnt;

  assign advance    = item_valid_q && free_i;
  assign in_ready_o = !item_valid_q || free_i;
  assign load_o     = advance;

  // Character classes against the active registers.
  always_comb begin
    logic [CHAR_W-1:0] c;
    c    = item_q.char_in;
    dcnt = (cfg_i.delim_count > 3'd4) ? 3'd4 : cfg_i.delim_count;
    is_delim = ((dcnt > 3'd0) && (c == cfg_i.delim[0])) ||
               ((dcnt > 3'd1) && (c == cfg_i.delim[1])) ||
               ((dcnt > 3'd2) && (c == cfg_i.delim[2])) ||
               ((dcnt > 3'd3) && (c == cfg_i.delim[3]));
    is_quote = (c == cfg_i.quote[0]) ||
               ((cfg_i.quote_count >= 2'd2) && (c == cfg_i.quote[1]));
    is_white = (c == SPACE_CHAR) || ((c >= TAB_CHAR) && (c <= CR_CHAR));
  end

  always_comb begin
    logic [CHAR_W-1:0]    c;
    logic [RES_CNT_W-1:0] n;
    bundle_t              b;
    c    = item_q.char_in;
    n    = '0;
    b    = '0;
    st_d = st_q;

    if (item_q.char_present && !(st_q.skip_spaces && is_white)) begin
      st_d.skip_spaces = 1'b0;
      if (st_q.escape_pending) begin
        st_d.escape_pending = 1'b0;
        b.res[n].kind        = KIND_CHAR;
        b.res[n].char_value  = c;
        b.res[n].field_index = st_q.field_counter;
        n = n + 2'd1;
        st_d.field_nonempty = 1'b1;
      end else if (c == ESCAPE_CHAR) begin
        st_d.escape_pending = 1'b1;
      end else if (!st_q.in_quote && !st_q.field_nonempty && is_quote) begin
        st_d.in_quote        = 1'b1;
        st_d.open_quote_char = c;
      end else if (st_q.in_quote && (c == st_q.open_quote_char)) begin
        st_d.in_quote        = 1'b0;
        st_d.open_quote_char = '0;
      end else if (!st_q.in_quote && is_delim) begin
        b.res[n].kind        = KIND_FIELD_END;
        b.res[n].field_index = st_q.field_counter;
        n = n + 2'd1;
        if (st_q.field_counter < MaxCnt) begin
          st_d.field_counter = st_q.field_counter + 8'd1;
        end
        st_d.field_nonempty = 1'b0;
        st_d.skip_spaces    = 1'b1;
      end else begin
        b.res[n].kind        = KIND_CHAR;
        b.res[n].char_value  = c;
        b.res[n].field_index = st_q.field_counter;
        n = n + 2'd1;
        st_d.field_nonempty = 1'b1;
      end
    end

    if (item_q.end_of_line) begin
      if (st_d.field_nonempty) begin
        b.res[n].kind        = KIND_FIELD_END;
        b.res[n].field_index = st_d.field_counter;
        n = n + 2'd1;
        if (st_d.field_counter < MaxCnt) begin
          st_d.field_counter = st_d.field_counter + 8'd1;
        end
      end
      b.res[n].kind        = KIND_ROW_END;
      b.res[n].field_count = st_d.field_counter;
      n = n + 2'd1;
      st_d = '0;
    end

    b.cnt    = n;
    bundle_o = b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      st_q         <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        item_valid_q <= 1'b1;
      end else if (advance) begin
        item_valid_q <= 1'b0;
      end
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ----- rtl/csvs_out_seq.sv -----
// Result register holding up to three tokens, sent out one per transfer.
module csvs_out_seq
  import csvs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  bundle_t bundle_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_res_o,
  output logic    out_last_o
);

  logic                      valid_q;
  logic [RES_CNT_W-1:0]      cnt_q, ptr_q;
  result_t [MAX_RESULTS-1:0] res_q;
  logic                      is_last, take;

  assign is_last     = (ptr_q == (cnt_q - 2'd1));
  assign take        = valid_q && out_ready_i;
  assign free_o      = !valid_q || (out_ready_i && is_last);
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q[ptr_q];
  assign out_last_o  = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      ptr_q   <= '0;
    end else if (load_i) begin
      valid_q <= (bundle_i.cnt != '0);
      cnt_q   <= bundle_i.cnt;
      ptr_q   <= '0;
    end else if (take) begin
      if (is_last) begin
        valid_q <= 1'b0;
      end else begin
        ptr_q <= ptr_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= bundle_i.res;
    end
  end

endmodule

// ----- sim/csv_field_splitter_tb.sv -----
// Self-checking testbench of the CSV field splitter: directed lines, then random lines per setting.
`timescale 1ns / 100ps

module csv_field_splitter_tb;
  import csvs_pkg::*;

  // Field index limit, shared by the block and the token predictor.
  localparam int unsigned FIELD_LIMIT = 255;
  // Cycles to hold after the last token before a register write or the end of the run.
  // One item yields at most three tokens, so this is ample.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Run limit in nanoseconds.
  localparam longint unsigned TIMEOUT_NS = 64'd5_000_000;

  // One output token as seen on the token channel.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_value;
    logic [7:0] field_index;
    logic [7:0] field_count;
    logic       last;
  } token_t;

  // Predicts the token stream of the splitter and checks the tokens that come out.
  class token_board #(int unsigned LIMIT = 255);
    cfg_t       cfg;
    tok_state_t st;
    token_t     expected_q[$];
    token_t     step_out[$];
    int         errors;

    function new();
      errors = 0;
      cfg    = '0;
      cfg.delim[0]    = DELIM_0_RST;
      cfg.delim_count = 3'd1;
      cfg.quote[0]    = QUOTE_0_RST;
      cfg.quote_count = 2'd1;
      st = '0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [7:0] v);
      case (idx)
        REG_DELIM_0:     cfg.delim[0] = v;
        REG_DELIM_1:     cfg.delim[1] = v;
        REG_DELIM_2:     cfg.delim[2] = v;
        REG_DELIM_3:     cfg.delim[3] = v;
        REG_DELIM_COUNT: cfg.delim_count = v[2:0];
        REG_QUOTE_0:     cfg.quote[0] = v;
        REG_QUOTE_1:     cfg.quote[1] = v;
        REG_QUOTE_COUNT: cfg.quote_count = v[1:0];
        default: ;
      endcase
    endfunction

    function bit is_delim(logic [7:0] c);
      int active;
      bit hit;
      // counts above four act as four
      active = (cfg.delim_count > 3'd4) ? 4 : int'(cfg.delim_count);
      hit = 1'b0;
      for (int k = 0; k < active; k++) if (c == cfg.delim[k]) hit = 1'b1;
      return hit;
    endfunction

    function bit is_quote(logic [7:0] c);
      return (c == cfg.quote[0]) || (cfg.quote_count >= 2'd2 && c == cfg.quote[1]);
    endfunction

    function bit is_white(logic [7:0] c);
      return (c == SPACE_CHAR) || (c >= TAB_CHAR && c <= CR_CHAR);
    endfunction

    function void emit(kind_e k, logic [7:0] ch, logic [7:0] idx, logic [7:0] cnt);
      token_t t;
      t.kind        = k;
      t.char_value  = ch;
      t.field_index = idx;
      t.field_count = cnt;
      t.last        = 1'b0;
      step_out = {step_out, t};
    endfunction

    function void close_field();
      emit(KIND_FIELD_END, 8'd0, st.field_counter, 8'd0);
      if (st.field_counter < LIMIT) st.field_counter++;
      st.field_nonempty = 1'b0;
    endfunction

    // Advance the predicted state by one accepted item and queue its tokens.
    function void note_item(item_t it);
      logic [7:0] c;
      token_t     t;
      int         n;
      step_out.delete();
      c = it.char_in;
      if (it.char_present && !(st.skip_spaces && is_white(c))) begin
        st.skip_spaces = 1'b0;
        if (st.escape_pending) begin
          st.escape_pending = 1'b0;
          emit(KIND_CHAR, c, st.field_counter, 8'd0);
          st.field_nonempty = 1'b1;
        end else if (c == ESCAPE_CHAR) begin
          st.escape_pending = 1'b1;
        end else if (!st.in_quote && !st.field_nonempty && is_quote(c)) begin
          st.in_quote        = 1'b1;
          st.open_quote_char = c;
        end else if (st.in_quote && c == st.open_quote_char) begin
          st.in_quote        = 1'b0;
          st.open_quote_char = 8'd0;
        end else if (!st.in_quote && is_delim(c)) begin
          close_field();
          st.skip_spaces = 1'b1;
        end else begin
          emit(KIND_CHAR, c, st.field_counter, 8'd0);
          st.field_nonempty = 1'b1;
        end
      end
      if (it.end_of_line) begin
        if (st.field_nonempty) close_field();
        emit(KIND_ROW_END, 8'd0, 8'd0, st.field_counter);
        st = '0;
      end
      n = step_out.size();
      for (int k = 0; k < n; k++) begin
        t = step_out[k];
        t.last = (k == n - 1);
        expected_q = {expected_q, t};
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (expected_q.size() == 0) begin
        $error("token with nothing expected: kind %0d char %0d index %0d count %0d",
               got.kind, got.char_value, got.field_index, got.field_count);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind", 8'(want.kind), 8'(got.kind));
      compare_field("char_value", want.char_value, got.char_value);
      compare_field("field_index", want.field_index, got.field_index);
      compare_field("field_count", want.field_count, got.field_count);
      compare_field("last", 8'(want.last), 8'(got.last));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  csvs_in_if  chr_if ();
  csvs_out_if tok_if ();

  token_board #(FIELD_LIMIT) sb;

  // When set, the sender or the receiver runs without any idle cycles.
  bit calm_tx;
  bit calm_rx;

  csv_field_splitter #(
    .MAX_FIELDS(FIELD_LIMIT)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .chr_i      (chr_if),
    .tok_o      (tok_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or loses a token.
  initial begin
    #(TIMEOUT_NS);
    $display("csv_field_splitter: mismatch");
    $finish;
  end

  // Receiver: ready changes at the falling edge. Most stalls are short; a few are long.
  initial begin
    int hold;
    int r;
    hold = 0;
    tok_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        tok_if.ready <= 1'b0;
        hold--;
      end else begin
        tok_if.ready <= 1'b1;
        if (!calm_rx) begin
          r = $urandom_range(0, 99);
          if (r < 20) hold = $urandom_range(1, 3);
          else if (r < 24) hold = $urandom_range(8, 30);
        end
      end
    end
  end

  // Check every token transfer against the oldest prediction, sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && tok_if.valid && tok_if.ready) begin
      sb.check_token(token_t'{kind: tok_if.kind, char_value: tok_if.char_value,
                              field_index: tok_if.field_index,
                              field_count: tok_if.field_count, last: tok_if.last});
    end
  end

  // Idle cycles ahead of the next item: none in calm stretches, else mostly none or short.
  function automatic int pick_gap();
    int r;
    if (calm_tx) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Line content biased toward the characters that steer the tokenizer.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'("a" + $urandom_range(0, 25));
    if (r < 45) return sb.cfg.delim[$urandom_range(0, 3)];
    if (r < 55) return sb.cfg.quote[$urandom_range(0, 1)];
    if (r < 65) return $urandom_range(0, 1) ? SPACE_CHAR : 8'($urandom_range(9, 13));
    if (r < 72) return ESCAPE_CHAR;
    if (r < 85) return 8'($urandom_range(0, 255));
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  // Register value for a random setting: half the time a punctuation mark, else any byte.
  function automatic logic [7:0] pick_cfg_char();
    string marks;
    marks = ",;:|\t\"'# ";
    if ($urandom_range(0, 1)) return marks[$urandom_range(0, marks.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Present one item from a falling edge and hold it until it transfers.
  // Returns at the falling edge after the transfer with valid still high.
  task automatic send_item(logic [7:0] ch, logic present, logic eol);
    item_t it;
    int    gap;
    it.char_in      = ch;
    it.char_present = present;
    it.end_of_line  = eol;
    gap = pick_gap();
    if (gap > 0) begin
      chr_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    chr_if.char_in      <= ch;
    chr_if.char_present <= present;
    chr_if.end_of_line  <= eol;
    chr_if.valid        <= 1'b1;
    do @(posedge clk_i); while (!chr_if.ready);
    sb.note_item(it);
    @(negedge clk_i);
  endtask

  // Send a string one character per item; optionally the last one ends the line.
  task automatic send_text(string s, bit eol);
    for (int k = 0; k < s.len(); k++) send_item(s[k], 1'b1, eol && (k == s.len() - 1));
  endtask

  // Drop valid and hold until every predicted token has transferred, then settle.
  task automatic drain_tokens();
    chr_if.valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    sb.write_reg(idx, v);
    @(negedge clk_i);
  endtask

  // Write all eight registers back to back; call only while the block is idle.
  task automatic set_config(logic [7:0] d0, logic [7:0] d1, logic [7:0] d2, logic [7:0] d3,
                            logic [7:0] dcnt, logic [7:0] q0, logic [7:0] q1,
                            logic [7:0] qcnt);
    write_reg(REG_DELIM_0, d0);
    write_reg(REG_DELIM_1, d1);
    write_reg(REG_DELIM_2, d2);
    write_reg(REG_DELIM_3, d3);
    write_reg(REG_DELIM_COUNT, dcnt);
    write_reg(REG_QUOTE_0, q0);
    write_reg(REG_QUOTE_1, q1);
    write_reg(REG_QUOTE_COUNT, qcnt);
    cfg_we_i <= 1'b0;
  endtask

  // Random lines of 0 to 11 characters, each closed by an end of line, with an
  // occasional empty item as noise. Only items that do something count.
  task automatic run_lines(int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      calm_tx = ($urandom_range(0, 5) == 0);
      calm_rx = ($urandom_range(0, 7) == 0);
      len = $urandom_range(0, 10);
      repeat (len) begin
        if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_item(pick_char(), 1'b1, 1'b0);
        sent++;
      end
      // the line ends either on a character or on an empty end-of-line item
      if ($urandom_range(0, 1)) send_item(pick_char(), 1'b1, 1'b1);
      else send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      sent++;
    end
  endtask

  initial begin
    sb = new();
    calm_tx = 1'b0;
    calm_rx = 1'b0;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = REG_DELIM_0;
    cfg_wdata_i         = '0;
    chr_if.valid        = 1'b0;
    chr_if.char_in      = '0;
    chr_if.char_present = 1'b0;
    chr_if.end_of_line  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed lines under the reset setting: comma delimiter, double quote.
    // empty line gives a row end with count zero; an empty item gives nothing
    send_item(8'd0, 1'b0, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    // spaces and a tab after a delimiter are skipped; last item carries three tokens
    send_text("a, \tbc", 1'b1);
    // quoted delimiter stays in the field, quotes themselves vanish
    send_text("\",\"x", 1'b0);
    send_item(8'd0, 1'b0, 1'b1);
    // escaped backslash and escaped delimiter, extreme bytes, an empty field
    send_text("\\\\\\,", 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_text(",,", 1'b1);
    // quote inside a non-empty field is a plain character
    send_text("a\"b", 1'b1);
    // pending escape dropped at end of line
    send_item(ESCAPE_CHAR, 1'b1, 1'b1);
    // leading space is kept when no delimiter precedes it
    send_text(" a", 1'b1);
    // open quote cut off by end of line
    send_text("\"q", 1'b1);
    drain_tokens();

    // Field counter saturation: one delimiter more than it takes to reach the limit.
    calm_tx = 1'b1;
    repeat (FIELD_LIMIT + 1) send_item(sb.cfg.delim[0], 1'b1, 1'b0);
    send_item("z", 1'b1, 1'b1);
    calm_tx = 1'b0;
    run_lines(8);
    drain_tokens();

    // Four delimiters, two quotes.
    set_config(",", ";", "\t", "|", 8'd4, "\"", "'", 8'd2);
    run_lines(6);
    drain_tokens();

    // No delimiters at all; quote count zero uses the first quote only.
    set_config(",", ":", ";", "\t", 8'd0, ",", "\"", 8'd0);
    run_lines(4);
    drain_tokens();

    // Out-of-range counts, a delimiter that is also the quote, a space delimiter
    // and a backslash as second quote (the escape always wins).
    set_config("\"", 8'h00, 8'hFF, " ", 8'hFF, "\"", ESCAPE_CHAR, 8'hFF);
    run_lines(4);
    drain_tokens();

    // Random settings.
    repeat (3) begin
      set_config(pick_cfg_char(), pick_cfg_char(), pick_cfg_char(), pick_cfg_char(),
                 8'($urandom_range(0, 255)), pick_cfg_char(), pick_cfg_char(),
                 8'($urandom_range(0, 255)));
      run_lines(3);
      drain_tokens();
    end

    if (sb.errors == 0) begin
      $display("csv_field_splitter: match");
    end else begin
      $display("csv_field_splitter: mismatch");
    end
    $finish;
  end

endmodule
